@@ src/bmm_pkg.sv @@
// Shared constants and types for the banked memory mapper.
`timescale 1ns / 1ps

package bmm_pkg;

    // Default sizes of the bank number space
    localparam int MAX_PROGRAM_BANKS_DEF = 64;
    localparam int MAX_PATTERN_BANKS_DEF = 256;
    localparam int BANK_W_DEF            = 8;

    // Bank memory: entries 0..5 hold pattern banks, 6 and 7 the two program banks
    localparam int          BANK_ENTRIES  = 8;
    localparam int          BANK_ADDR_W   = 3;
    localparam logic [2:0]  CHR_2K_LO_SEL = 3'd0;
    localparam logic [2:0]  CHR_2K_HI_SEL = 3'd1;
    localparam logic [2:0]  CHR_1K_SEL    = 3'd2;
    localparam logic [2:0]  PRG_BANK0_SEL = 3'd6;
    localparam logic [2:0]  PRG_BANK1_SEL = 3'd7;

    // Field widths
    localparam int MODE_W     = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int TARGET_W   = 2;
    localparam int INDEX_W    = 19;
    localparam int SIZE_W     = 14;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 14;
    localparam int BLOCKS_W   = 6;

    // Access kinds
    localparam logic [1:0] MODE_PRG_RD = 2'd0;
    localparam logic [1:0] MODE_PRG_WR = 2'd1;
    localparam logic [1:0] MODE_CHR_RD = 2'd2;
    localparam logic [1:0] MODE_CHR_WR = 2'd3;

    // Target memories
    localparam logic [1:0] TGT_NONE    = 2'd0;
    localparam logic [1:0] TGT_PRG_ROM = 2'd1;
    localparam logic [1:0] TGT_PRG_RAM = 2'd2;
    localparam logic [1:0] TGT_CHR_ROM = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRG_BLOCKS = 2'd0;
    localparam logic [1:0] CFG_CHR_BLOCKS = 2'd1;
    localparam logic [1:0] CFG_RAM_BYTES  = 2'd2;

    // Address map
    localparam logic [15:0] RAM_BASE = 16'h6000;
    localparam logic [15:0] REG_BASE = 16'h8000;
    localparam logic [15:0] CHR_TOP  = 16'h2000;
    localparam int          PRG_PAGE_SHIFT = 13;
    localparam int          CHR_PAGE_SHIFT = 10;

    // Remainder unit: 16-bit dividend, 4 quotient bits per cycle
    localparam int MOD_DVD_W = 16;
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = MOD_DVD_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    typedef struct packed {
        logic                  start;
        logic [MOD_DVD_W-1:0]  dividend;
        logic [SIZE_W-1:0]     divisor;
    } mod_req_t;

endpackage

@@ src/banked_memory_mapper_unit.sv @@
// Top level of the banked memory mapper: bus access decode, register file and sequencing.
`timescale 1ns / 1ps

// Translates one bus access word into a target memory and byte index. Program ROM
// is seen as four 8 KiB windows (two switchable, two fixed to the last banks),
// pattern ROM as two 2 KiB and four 1 KiB switchable windows, program RAM as a
// window of program_ram_bytes bytes at 0x6000. Program writes at 0x8000 and up
// update the mapper registers and return target none. The bank numbers live in an
// 8-entry synchronous memory, read with the accept and registered for decode. ROM reads,
// register writes other than a bank number, and error accesses pass from accept to
// result through the memory read, then the decode. RAM window accesses and
// bank-number writes also need a modulo by the RAM size or bank count, which runs
// in a shared remainder unit that retires 4 dividend bits per cycle.
// One access is in flight at a time; a new word is taken as soon as the previous
// result has moved into the output register, even if that register is stalled.
// No clearing pass runs after reset. Configuration writes are taken at any time
// but must only be issued while the block is idle.
module banked_memory_mapper_unit #(
    parameter int MAX_PROGRAM_BANKS = bmm_pkg::MAX_PROGRAM_BANKS_DEF,
    parameter int MAX_PATTERN_BANKS = bmm_pkg::MAX_PATTERN_BANKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // access input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // index[18:0], write_enable[19], write_data[27:20],
                                   // error[28], mirroring[29], irq_enabled[30], zero[31]
    output logic [1:0]  m_tuser,   // target[1:0]
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [bmm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bmm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PRG_W  = (MAX_PROGRAM_BANKS > 2) ? $clog2(MAX_PROGRAM_BANKS) : 1;
    localparam int CHR_W  = $clog2(MAX_PATTERN_BANKS);
    localparam int BANK_W = (PRG_W > CHR_W) ? PRG_W : CHR_W;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // register region, address bits 14:13 above 0x8000
    localparam logic [1:0] REG_BANK       = 2'd0;
    localparam logic [1:0] REG_MIRROR     = 2'd1;
    localparam logic [1:0] REG_IRQ_RELOAD = 2'd2;
    localparam logic [1:0] REG_IRQ_EN     = 2'd3;

    logic [1:0] state_reg, state_next;

    // held access
    logic [1:0]  mode_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    // configuration
    logic [bmm_pkg::BLOCKS_W-1:0] prg_blocks_reg;
    logic [bmm_pkg::BLOCKS_W-1:0] chr_blocks_reg;
    logic [bmm_pkg::SIZE_W-1:0]   ram_bytes_reg;

    // mapper registers (irq reload value has no visible effect and is not kept)
    logic [2:0] bank_select_reg, bank_select_next;
    logic       prg_mode_reg, prg_mode_next;
    logic       chr_mode_reg, chr_mode_next;
    logic       mirror_reg, mirror_next;
    logic       irq_on_reg, irq_on_next;
    logic       div_bank_reg, div_bank_next;

    // parked result when the output register is busy
    logic [1:0]  res_tgt_reg;
    logic [18:0] res_index_reg;
    logic        res_we_reg;
    logic [7:0]  res_wd_reg;
    logic        res_err_reg;

    // output register
    logic        m_tvalid_reg;
    logic [1:0]  out_tgt_reg;
    logic [18:0] out_index_reg;
    logic        out_we_reg;
    logic [7:0]  out_wd_reg;
    logic        out_err_reg;
    logic        out_mirror_reg;
    logic        out_irq_reg;

    // finishing result of this cycle
    logic        fin_valid;
    logic [1:0]  fin_tgt;
    logic [18:0] fin_index;
    logic        fin_we;
    logic [7:0]  fin_wd;
    logic        fin_err;

    logic        accept;
    logic        out_free;

    // bank memory
    logic                            ram_we;
    logic [bmm_pkg::BANK_ADDR_W-1:0] ram_raddr;
    logic [BANK_W-1:0]               ram_rdata;

    // remainder unit
    bmm_pkg::mod_req_t             mod_req;
    logic                          mod_done;
    logic [bmm_pkg::SIZE_W-1:0]    mod_rem;

    // derived sizes
    logic [bmm_pkg::SIZE_W-1:0] prg_cnt, prg_raw;
    logic [bmm_pkg::SIZE_W-1:0] chr_cnt, chr_raw;
    logic [bmm_pkg::BLOCKS_W-1:0] chr_blocks_eff;
    logic [bmm_pkg::SIZE_W-1:0] ram_size;

    // address decode
    logic [12:0] in_chr_a, chr_a;
    logic [10:0] chr_off;
    logic [bmm_pkg::SIZE_W-1:0] prg_bank;
    logic [18:0] prg_index, chr_index;
    logic [7:0]  bank_value;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // bank counts, clamped to the supported range
    assign prg_raw = {{(bmm_pkg::SIZE_W-bmm_pkg::BLOCKS_W-1){1'b0}}, prg_blocks_reg, 1'b0};
    assign prg_cnt = (prg_raw < bmm_pkg::SIZE_W'(2)) ? bmm_pkg::SIZE_W'(2) :
                     (prg_raw > bmm_pkg::SIZE_W'(MAX_PROGRAM_BANKS)) ?
                     bmm_pkg::SIZE_W'(MAX_PROGRAM_BANKS) : prg_raw;
    assign chr_blocks_eff = (chr_blocks_reg == '0) ? bmm_pkg::BLOCKS_W'(1) : chr_blocks_reg;
    assign chr_raw = {{(bmm_pkg::SIZE_W-bmm_pkg::BLOCKS_W-3){1'b0}}, chr_blocks_eff, 3'b000};
    assign chr_cnt = (chr_raw < bmm_pkg::SIZE_W'(8)) ? bmm_pkg::SIZE_W'(8) :
                     (chr_raw > bmm_pkg::SIZE_W'(MAX_PATTERN_BANKS)) ?
                     bmm_pkg::SIZE_W'(MAX_PATTERN_BANKS) : chr_raw;
    assign ram_size = (ram_bytes_reg == '0) ? bmm_pkg::SIZE_W'(1) : ram_bytes_reg;

    // bank memory read address, issued with the accept
    assign in_chr_a = s_tdata[12:0] ^ {chr_mode_reg, 12'b0};
    always_comb
    begin
        if (s_tuser[1])
        begin
            ram_raddr = in_chr_a[12] ? (bmm_pkg::CHR_1K_SEL + {1'b0, in_chr_a[11:10]}) :
                                       {2'b00, in_chr_a[11]};
        end
        else
        begin
            ram_raddr = (s_tdata[14:13] == 2'd1) ? bmm_pkg::PRG_BANK1_SEL :
                                                   bmm_pkg::PRG_BANK0_SEL;
        end
    end

    // program ROM: windows 0 and 2 swap with program_mode, window 3 is the last bank
    always_comb
    begin
        case (addr_reg[14:13])
            2'd0:
                prg_bank = prg_mode_reg ? (prg_cnt - bmm_pkg::SIZE_W'(2)) :
                                          bmm_pkg::SIZE_W'(ram_rdata);
            2'd1:
                prg_bank = bmm_pkg::SIZE_W'(ram_rdata);
            2'd2:
                prg_bank = prg_mode_reg ? bmm_pkg::SIZE_W'(ram_rdata) :
                                          (prg_cnt - bmm_pkg::SIZE_W'(2));
            default:
                prg_bank = prg_cnt - bmm_pkg::SIZE_W'(1);
        endcase
    end
    assign prg_index = (19'(prg_bank) << bmm_pkg::PRG_PAGE_SHIFT) + 19'(addr_reg[12:0]);

    // pattern ROM: 2 KiB windows below 0x1000, 1 KiB above, halves swap with pattern_mode
    assign chr_a     = addr_reg[12:0] ^ {chr_mode_reg, 12'b0};
    assign chr_off   = chr_a[12] ? {1'b0, chr_a[9:0]} : chr_a[10:0];
    assign chr_index = (19'(ram_rdata) << bmm_pkg::CHR_PAGE_SHIFT) + 19'(chr_off);

    // bank number before reduction: 2 KiB slots are even, program banks 6 bits
    always_comb
    begin
        if (bank_select_reg >= bmm_pkg::PRG_BANK0_SEL)
        begin
            bank_value = data_reg & 8'h3F;
        end
        else if (bank_select_reg <= bmm_pkg::CHR_2K_HI_SEL)
        begin
            bank_value = data_reg & 8'hFE;
        end
        else
        begin
            bank_value = data_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        bank_select_next = bank_select_reg;
        prg_mode_next    = prg_mode_reg;
        chr_mode_next    = chr_mode_reg;
        mirror_next      = mirror_reg;
        irq_on_next      = irq_on_reg;
        div_bank_next    = div_bank_reg;
        mod_req          = '0;
        ram_we           = 1'b0;
        fin_valid        = 1'b0;
        fin_tgt          = bmm_pkg::TGT_NONE;
        fin_index        = '0;
        fin_we           = 1'b0;
        fin_wd           = '0;
        fin_err          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (!mode_reg[1])
                begin
                    if (addr_reg < bmm_pkg::RAM_BASE)
                    begin
                        fin_valid = 1'b1;
                        fin_err   = 1'b1;
                    end
                    else if (addr_reg < bmm_pkg::REG_BASE)
                    begin
                        // RAM window: offset modulo the window size
                        mod_req.start    = 1'b1;
                        mod_req.dividend = bmm_pkg::MOD_DVD_W'(addr_reg[12:0]);
                        mod_req.divisor  = ram_size;
                        div_bank_next    = 1'b0;
                        state_next       = S_DIV;
                    end
                    else if (mode_reg == bmm_pkg::MODE_PRG_RD)
                    begin
                        fin_valid = 1'b1;
                        fin_tgt   = bmm_pkg::TGT_PRG_ROM;
                        fin_index = prg_index;
                    end
                    else
                    begin
                        fin_valid = 1'b1;
                        case (addr_reg[14:13])
                            REG_BANK:
                            begin
                                if (!addr_reg[0])
                                begin
                                    chr_mode_next    = data_reg[7];
                                    prg_mode_next    = data_reg[6];
                                    bank_select_next = data_reg[2:0];
                                end
                                else
                                begin
                                    // bank number write: reduce before storing
                                    fin_valid        = 1'b0;
                                    mod_req.start    = 1'b1;
                                    mod_req.dividend = bmm_pkg::MOD_DVD_W'(bank_value);
                                    mod_req.divisor  =
                                        (bank_select_reg >= bmm_pkg::PRG_BANK0_SEL) ?
                                        prg_cnt : chr_cnt;
                                    div_bank_next    = 1'b1;
                                    state_next       = S_DIV;
                                end
                            end
                            REG_MIRROR:
                            begin
                                if (!addr_reg[0])
                                begin
                                    mirror_next = data_reg[0];
                                end
                            end
                            REG_IRQ_RELOAD:
                            begin
                                // reload value and reload request: nothing observable
                            end
                            REG_IRQ_EN:
                            begin
                                irq_on_next = addr_reg[0];
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                else if (mode_reg == bmm_pkg::MODE_CHR_RD && addr_reg < bmm_pkg::CHR_TOP)
                begin
                    fin_valid = 1'b1;
                    fin_tgt   = bmm_pkg::TGT_CHR_ROM;
                    fin_index = chr_index;
                end
                else
                begin
                    // pattern writes and pattern reads above the pattern space
                    fin_valid = 1'b1;
                    fin_err   = 1'b1;
                end
            end
            S_DIV:
            begin
                if (mod_done)
                begin
                    fin_valid = 1'b1;
                    if (div_bank_reg)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        fin_tgt   = bmm_pkg::TGT_PRG_RAM;
                        fin_index = 19'(mod_rem);
                        fin_we    = (mode_reg == bmm_pkg::MODE_PRG_WR);
                        fin_wd    = fin_we ? data_reg : 8'h00;
                    end
                end
            end
            S_DONE:
            begin
                fin_valid = 1'b1;
                fin_tgt   = res_tgt_reg;
                fin_index = res_index_reg;
                fin_we    = res_we_reg;
                fin_wd    = res_wd_reg;
                fin_err   = res_err_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin_valid)
        begin
            state_next = out_free ? S_IDLE : S_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            bank_select_reg <= '0;
            prg_mode_reg    <= 1'b0;
            chr_mode_reg    <= 1'b0;
            mirror_reg      <= 1'b0;
            irq_on_reg      <= 1'b0;
            div_bank_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            prg_blocks_reg  <= bmm_pkg::BLOCKS_W'(2);
            chr_blocks_reg  <= bmm_pkg::BLOCKS_W'(1);
            ram_bytes_reg   <= bmm_pkg::SIZE_W'(8192);
        end
        else
        begin
            state_reg       <= state_next;
            bank_select_reg <= bank_select_next;
            prg_mode_reg    <= prg_mode_next;
            chr_mode_reg    <= chr_mode_next;
            mirror_reg      <= mirror_next;
            irq_on_reg      <= irq_on_next;
            div_bank_reg    <= div_bank_next;
            if (fin_valid && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bmm_pkg::CFG_PRG_BLOCKS: prg_blocks_reg <= cfg_data[bmm_pkg::BLOCKS_W-1:0];
                    bmm_pkg::CFG_CHR_BLOCKS: chr_blocks_reg <= cfg_data[bmm_pkg::BLOCKS_W-1:0];
                    bmm_pkg::CFG_RAM_BYTES:  ram_bytes_reg  <= cfg_data[bmm_pkg::SIZE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_tuser;
            addr_reg <= s_tdata[15:0];
            data_reg <= s_tdata[23:16];
        end
        if (fin_valid && out_free)
        begin
            out_tgt_reg    <= fin_tgt;
            out_index_reg  <= fin_index;
            out_we_reg     <= fin_we;
            out_wd_reg     <= fin_wd;
            out_err_reg    <= fin_err;
            out_mirror_reg <= mirror_next;
            out_irq_reg    <= irq_on_next;
        end
        else if (fin_valid)
        begin
            res_tgt_reg   <= fin_tgt;
            res_index_reg <= fin_index;
            res_we_reg    <= fin_we;
            res_wd_reg    <= fin_wd;
            res_err_reg   <= fin_err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_tgt_reg;
    assign m_tdata  = {1'b0, out_irq_reg, out_mirror_reg, out_err_reg,
                       out_wd_reg, out_we_reg, out_index_reg};

    bmm_bank_ram #(
        .BANK_W (BANK_W)
    ) u_bank_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ram_we),
        .waddr (bank_select_reg),
        .wdata (mod_rem[BANK_W-1:0]),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bmm_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    // an accepted word always goes to the lookup cycle next
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_LOOK)
        else $error("accepted word did not enter lookup");

    // the remainder unit only finishes while the sequencer waits for it
    a_mod_done_div: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == S_DIV)
        else $error("remainder finished outside wait state");

    // a write strobe on the output only goes with program RAM
    a_we_ram: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[19]) |-> m_tuser == bmm_pkg::TGT_PRG_RAM)
        else $error("write enable without RAM target");

    // an error result has no target and a zero index
    a_err_none: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[28]) |-> (m_tuser == bmm_pkg::TGT_NONE && m_tdata[18:0] == '0))
        else $error("error word carries a target");

endmodule

@@ src/bmm_bank_ram.sv @@
// Bank number memory: 8 entries, one write and one registered read port.
`timescale 1ns / 1ps

module bmm_bank_ram #(
    parameter int BANK_W = bmm_pkg::BANK_W_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            we,
    input  logic [bmm_pkg::BANK_ADDR_W-1:0] waddr,
    input  logic [BANK_W-1:0]               wdata,
    input  logic                            re,
    input  logic [bmm_pkg::BANK_ADDR_W-1:0] raddr,
    output logic [BANK_W-1:0]               rdata
);

    logic [BANK_W-1:0]               mem [bmm_pkg::BANK_ENTRIES];
    logic [bmm_pkg::BANK_ENTRIES-1:0] valid_reg;
    logic [BANK_W-1:0]               rd_data_reg;
    logic                            rd_valid_reg;
    logic [bmm_pkg::BANK_ADDR_W-1:0] rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
            rd_addr_reg <= raddr;
        end
    end

    // entries never written read as their reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    // program bank 1 resets to bank one, everything else to zero
    assign rdata = rd_valid_reg ? rd_data_reg :
                   (rd_addr_reg == bmm_pkg::PRG_BANK1_SEL) ? BANK_W'(1) : '0;

endmodule

@@ src/bmm_mod_unit.sv @@
// Iterative remainder unit, four dividend bits per cycle.
`timescale 1ns / 1ps

module bmm_mod_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bmm_pkg::mod_req_t          req,
    output logic                       done,
    output logic [bmm_pkg::SIZE_W-1:0] rem
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [bmm_pkg::MOD_CNT_W-1:0]  cnt_reg;
    logic [bmm_pkg::MOD_DVD_W-1:0]  dvd_reg;
    logic [bmm_pkg::SIZE_W-1:0]     dsr_reg;
    logic [bmm_pkg::SIZE_W-1:0]     rem_reg;
    logic [bmm_pkg::SIZE_W-1:0]     rem_next;

    // restoring remainder steps; partial remainder stays below the divisor
    always_comb
    begin
        logic [bmm_pkg::SIZE_W:0] r;
        rem_next = rem_reg;
        for (int i = 0; i < bmm_pkg::MOD_BITS; i++)
        begin
            r = {rem_next, dvd_reg[bmm_pkg::MOD_DVD_W-1-i]};
            if (r >= {1'b0, dsr_reg})
            begin
                r = r - {1'b0, dsr_reg};
            end
            rem_next = r[bmm_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + bmm_pkg::MOD_CNT_W'(1);
                if (cnt_reg == bmm_pkg::MOD_CNT_W'(bmm_pkg::MOD_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << bmm_pkg::MOD_BITS;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ sim/banked_memory_mapper_unit_tb.sv @@
// Self-checking testbench for the banked memory mapper: directed and random bus accesses.
`timescale 1ns / 1ps

module banked_memory_mapper_unit_tb;

    // Register windows above REG_BASE, selected by address bits 14..13
    localparam logic [15:0] MIRROR_REG     = 16'hA000;
    localparam logic [15:0] IRQ_RELOAD_REG = 16'hC000;
    localparam logic [15:0] IRQ_EN_REG     = 16'hE000;

    localparam int MAX_GAP      = 13;
    localparam int DRAIN_CYCLES = 12;    // longest access waits on the remainder unit, plus margin
    localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on any channel
    localparam int LONG_HOLD    = 300;

    // One translated access, as it leaves the block
    typedef struct {
        logic [bmm_pkg::TARGET_W-1:0] target;
        logic [bmm_pkg::INDEX_W-1:0]  index;
        logic                         we;
        logic [bmm_pkg::DATA_W-1:0]   wd;
        logic                         err;
        logic                         mirror;
        logic                         irq;
    } xlat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [bmm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bmm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    banked_memory_mapper_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mapper shadow: configuration and register state as the block should hold it
    // ------------------------------------------------------------------
    logic [bmm_pkg::BLOCKS_W-1:0] prg_blocks_cfg = 6'd2;
    logic [bmm_pkg::BLOCKS_W-1:0] chr_blocks_cfg = 6'd1;
    logic [bmm_pkg::SIZE_W-1:0]   ram_bytes_cfg  = 14'd8192;
    logic [2:0]          bank_sel  = '0;
    logic                prg_mode  = 1'b0;
    logic                chr_mode  = 1'b0;
    logic                mirror_mode = 1'b0;
    logic                irq_on    = 1'b0;
    logic [7:0]          chr_bank [6] = '{default: 8'd0};
    logic [5:0]          prg_bank [2] = '{6'd0, 6'd1};

    xlat_t xlat_due[$];     // translations accepted but not yet seen at the output
    xlat_t want;
    int    mismatch_count = 0;
    int    idle_cycles = 0;
    int    hold_req = 0;     // one-shot long hold-off for the result side
    bit    gaps_on = 1'b1;   // random gaps on both sides

    function automatic int prg_bank_count();
        int n;
        n = int'(prg_blocks_cfg) * 2;
        if (n < 2) n = 2;
        if (n > bmm_pkg::MAX_PROGRAM_BANKS_DEF) n = bmm_pkg::MAX_PROGRAM_BANKS_DEF;
        return n;
    endfunction

    function automatic int chr_bank_count();
        int n;
        n = (chr_blocks_cfg == 0 ? 1 : int'(chr_blocks_cfg)) * 8;
        if (n < 8) n = 8;
        if (n > bmm_pkg::MAX_PATTERN_BANKS_DEF) n = bmm_pkg::MAX_PATTERN_BANKS_DEF;
        return n;
    endfunction

    // Register write at REG_BASE and up; bank numbers are reduced when stored
    function automatic void write_mapper_reg(logic [15:0] addr, logic [7:0] data);
        logic odd;
        odd = addr[0];
        if (addr < MIRROR_REG)
        begin
            if (!odd)
            begin
                chr_mode = data[7];
                prg_mode = data[6];
                bank_sel = data[2:0];
            end
            else if (bank_sel >= bmm_pkg::PRG_BANK0_SEL)
                prg_bank[bank_sel - bmm_pkg::PRG_BANK0_SEL] =
                    6'(int'(data[5:0]) % prg_bank_count());
            else if (bank_sel <= bmm_pkg::CHR_2K_HI_SEL)
                chr_bank[bank_sel] = 8'(int'({data[7:1], 1'b0}) % chr_bank_count());
            else
                chr_bank[bank_sel] = 8'(int'(data) % chr_bank_count());
        end
        else if (addr < IRQ_RELOAD_REG)
        begin
            if (!odd) mirror_mode = data[0];   // odd: RAM protect, ignored
        end
        else if (addr < IRQ_EN_REG)
        begin
            // reload value and reload request: nothing observable
        end
        else
            irq_on = odd;
    endfunction

    // Four 8 KiB windows; the last two banks follow the current size
    function automatic int prg_rom_index(logic [15:0] addr);
        int count;
        int bank;
        count = prg_bank_count();
        case (addr[14:13])
            2'd0:    bank = prg_mode ? count - 2 : int'(prg_bank[0]);
            2'd1:    bank = int'(prg_bank[1]);
            2'd2:    bank = prg_mode ? int'(prg_bank[0]) : count - 2;
            default: bank = count - 1;
        endcase
        return bank * 'h2000 + int'(addr[12:0]);
    endfunction

    // Two 2 KiB windows then four 1 KiB windows, swapped halves in inverted mode
    function automatic int chr_rom_index(logic [15:0] addr);
        logic [15:0] a;
        a = chr_mode ? (addr ^ 16'h1000) : addr;
        if (a < 16'h0800) return int'(chr_bank[0]) * 'h400 + int'(a[10:0]);
        if (a < 16'h1000) return int'(chr_bank[1]) * 'h400 + int'(a[10:0]);
        return int'(chr_bank[2 + a[11:10]]) * 'h400 + int'(a[9:0]);
    endfunction

    function automatic xlat_t translate_access(logic [1:0] mode, logic [15:0] addr,
                                               logic [7:0] data);
        xlat_t r;
        int    size;
        r = '{default: '0};
        if (mode == bmm_pkg::MODE_PRG_RD || mode == bmm_pkg::MODE_PRG_WR)
        begin
            if (addr < bmm_pkg::RAM_BASE)
                r.err = 1'b1;
            else if (addr < bmm_pkg::REG_BASE)
            begin
                size = (ram_bytes_cfg == 0) ? 1 : int'(ram_bytes_cfg);
                r.target = bmm_pkg::TGT_PRG_RAM;
                r.index  = bmm_pkg::INDEX_W'((int'(addr) - int'(bmm_pkg::RAM_BASE)) % size);
                if (mode == bmm_pkg::MODE_PRG_WR)
                begin
                    r.we = 1'b1;
                    r.wd = data;
                end
            end
            else if (mode == bmm_pkg::MODE_PRG_RD)
            begin
                r.target = bmm_pkg::TGT_PRG_ROM;
                r.index  = bmm_pkg::INDEX_W'(prg_rom_index(addr));
            end
            else
                write_mapper_reg(addr, data);
        end
        else if (mode == bmm_pkg::MODE_CHR_RD && addr < bmm_pkg::CHR_TOP)
        begin
            r.target = bmm_pkg::TGT_CHR_ROM;
            r.index  = bmm_pkg::INDEX_W'(chr_rom_index(addr));
        end
        else
            r.err = 1'b1;
        r.mirror = mirror_mode;
        r.irq    = irq_on;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Access sender. Valid is only dropped when a gap follows, so back-to-back
    // words never see valid lowered and raised in the same step.
    // ------------------------------------------------------------------
    task automatic send_access(input logic [1:0] mode, input logic [15:0] addr,
                               input logic [7:0] data);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {data, addr};
        do @(posedge clk); while (!s_tready);
        xlat_due.push_back(translate_access(mode, addr, data));
    endtask

    // Every access yields one word, so an empty queue plus the pipeline depth means idle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (xlat_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [bmm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bmm_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bmm_pkg::CFG_PRG_BLOCKS: prg_blocks_cfg = value[bmm_pkg::BLOCKS_W-1:0];
            bmm_pkg::CFG_CHR_BLOCKS: chr_blocks_cfg = value[bmm_pkg::BLOCKS_W-1:0];
            bmm_pkg::CFG_RAM_BYTES:  ram_bytes_cfg  = value;
            default: ;
        endcase
    endtask

    // All three sizes, written back to back while the block is idle
    task automatic configure(input logic [bmm_pkg::CFG_DATA_W-1:0] prg,
                             input logic [bmm_pkg::CFG_DATA_W-1:0] chr,
                             input logic [bmm_pkg::CFG_DATA_W-1:0] ram);
        wait_idle();
        cfg_write(bmm_pkg::CFG_PRG_BLOCKS, prg);
        cfg_write(bmm_pkg::CFG_CHR_BLOCKS, chr);
        cfg_write(bmm_pkg::CFG_RAM_BYTES, ram);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic: ROM/RAM reads and writes, select+bank pairs,
    // other register writes, plus fully random words as noise.
    task automatic random_access();
        int          pick;
        logic [15:0] a;
        logic [15:0] b;
        logic [7:0]  d;
        logic [7:0]  e;
        pick = $urandom_range(0, 99);
        a = 16'($urandom);
        b = 16'($urandom);
        d = 8'($urandom);
        e = 8'($urandom);
        if (pick < 25)
            send_access(bmm_pkg::MODE_PRG_RD, {1'b1, a[14:0]}, d);
        else if (pick < 45)
            send_access(bmm_pkg::MODE_CHR_RD, {3'b000, a[12:0]}, d);
        else if (pick < 60)
            send_access(pick < 52 ? bmm_pkg::MODE_PRG_RD : bmm_pkg::MODE_PRG_WR,
                        {3'b011, a[12:0]}, d);
        else if (pick < 75)
        begin
            send_access(bmm_pkg::MODE_PRG_WR, {3'b100, a[12:1], 1'b0}, d);
            send_access(bmm_pkg::MODE_PRG_WR, {3'b100, b[12:1], 1'b1}, e);
        end
        else if (pick < 85)
            send_access(bmm_pkg::MODE_PRG_WR, {1'b1, a[14:0]}, d);
        else
            send_access(b[1:0], a, d);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Range edges, every access kind and every register at reset sizes
    task automatic test_directed_accesses();
        send_access(bmm_pkg::MODE_PRG_RD, bmm_pkg::REG_BASE, 8'h00);
        send_access(bmm_pkg::MODE_PRG_RD, 16'hFFFF, 8'hFF);
        send_access(bmm_pkg::MODE_PRG_RD, 16'h0000, 8'h00);          // low program address
        send_access(bmm_pkg::MODE_PRG_WR, bmm_pkg::RAM_BASE - 16'd1, 8'hFF); // low address
        send_access(bmm_pkg::MODE_PRG_RD, bmm_pkg::RAM_BASE, 8'h00);
        send_access(bmm_pkg::MODE_PRG_WR, bmm_pkg::REG_BASE - 16'd1, 8'hFF);
        send_access(bmm_pkg::MODE_CHR_RD, 16'h0000, 8'h00);
        send_access(bmm_pkg::MODE_CHR_RD, bmm_pkg::CHR_TOP - 16'd1, 8'hFF);
        send_access(bmm_pkg::MODE_CHR_RD, bmm_pkg::CHR_TOP, 8'h00);  // high pattern address
        send_access(bmm_pkg::MODE_CHR_WR, 16'h0400, 8'hFF);          // pattern write
        send_access(bmm_pkg::MODE_PRG_WR, bmm_pkg::REG_BASE,
                    {2'b11, 3'b000, bmm_pkg::PRG_BANK1_SEL});
        send_access(bmm_pkg::MODE_PRG_WR, bmm_pkg::REG_BASE | 16'd1, 8'hFF);
        send_access(bmm_pkg::MODE_PRG_WR, bmm_pkg::REG_BASE,
                    {2'b11, 3'b000, bmm_pkg::CHR_2K_LO_SEL});
        send_access(bmm_pkg::MODE_PRG_WR, bmm_pkg::REG_BASE | 16'd1, 8'hFF);
        send_access(bmm_pkg::MODE_PRG_WR, MIRROR_REG, 8'hFF);
        send_access(bmm_pkg::MODE_PRG_WR, MIRROR_REG | 16'd1, 8'h00);
        send_access(bmm_pkg::MODE_PRG_WR, IRQ_RELOAD_REG, 8'hAB);
        send_access(bmm_pkg::MODE_PRG_WR, IRQ_RELOAD_REG | 16'd1, 8'h55);
        send_access(bmm_pkg::MODE_PRG_WR, IRQ_EN_REG | 16'd1, 8'h00);
        send_access(bmm_pkg::MODE_PRG_RD, 16'hC000, 8'h00);
        send_access(bmm_pkg::MODE_CHR_RD, 16'h1800, 8'h00);
        send_access(bmm_pkg::MODE_PRG_WR, IRQ_EN_REG, 8'hFF);
        send_access(bmm_pkg::MODE_CHR_WR, 16'hFFFF, 8'h00);
    endtask

    // Banks stored under a large ROM keep their value when the ROM shrinks;
    // the fixed last two program banks move with the size.
    task automatic test_size_change();
        configure(14'd32, 14'd32, 14'd8192);
        send_access(bmm_pkg::MODE_PRG_WR, bmm_pkg::REG_BASE,
                    {2'b00, 3'b000, bmm_pkg::PRG_BANK0_SEL});
        send_access(bmm_pkg::MODE_PRG_WR, bmm_pkg::REG_BASE | 16'd1, 8'hFF);
        send_access(bmm_pkg::MODE_PRG_WR, bmm_pkg::REG_BASE,
                    {2'b00, 3'b000, bmm_pkg::CHR_1K_SEL});
        send_access(bmm_pkg::MODE_PRG_WR, bmm_pkg::REG_BASE | 16'd1, 8'hFF);
        configure(14'd1, 14'd1, 14'd100);
        send_access(bmm_pkg::MODE_PRG_RD, bmm_pkg::REG_BASE, 8'h00);
        send_access(bmm_pkg::MODE_PRG_RD, 16'hE000, 8'h00);
        send_access(bmm_pkg::MODE_CHR_RD, 16'h1000, 8'h00);
        send_access(bmm_pkg::MODE_PRG_WR, 16'h7FFF, 8'h5A);
    endtask

    // Phases over size extremes (incl. zero and all-ones words) and random sizes
    task automatic test_random_traffic();
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       configure(14'd1, 14'd0, 14'd1);
                1:       configure(14'h3FFF, 14'h3FFF, 14'h3FFF);
                2:       configure(14'd32, 14'd32, 14'd8192);
                3:       configure(14'd0, 14'd0, 14'd0);
                4:       configure(14'd2, 14'd1, 14'd8192);
                default: configure(14'($urandom_range(1, 32)), 14'($urandom_range(0, 32)),
                                   14'($urandom_range(1, 8192)));
            endcase
            gaps_on = (p % 3 != 2);   // some phases run back to back on both sides
            repeat (190) random_access();
        end
        gaps_on = 1'b1;
    endtask

    // Result side holds off while words keep coming: the block fills and stalls
    task automatic test_output_stall();
        configure(14'($urandom_range(1, 32)), 14'($urandom_range(0, 32)),
                  14'($urandom_range(1, 8192)));
        hold_req = LONG_HOLD;
        gaps_on  = 1'b0;
        repeat (60) random_access();
        gaps_on  = 1'b1;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_accesses();
        test_size_change();
        test_random_traffic();
        test_output_stall();
        wait_idle();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result-side ready: random hold-off before each word, or one long hold on request
    initial
    begin : result_ready
        int stall;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                stall = hold_req;
                hold_req = 0;
            end
            else
                stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // Result checker: each accepted word against the oldest translation due
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (xlat_due.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %0h/%0h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = xlat_due.pop_front();
                check_field("target", want.target, m_tuser);
                check_field("index", want.index, m_tdata[18:0]);
                check_field("write_enable", want.we, m_tdata[19]);
                check_field("write_data", want.wd, m_tdata[27:20]);
                check_field("error", want.err, m_tdata[28]);
                check_field("mirroring", want.mirror, m_tdata[29]);
                check_field("irq_enabled", want.irq, m_tdata[30]);
                check_field("pad bit", 0, m_tdata[31]);
            end
        end
    end

    // Watchdog: no word moved on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no progress for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

@@ files.f @@
src/bmm_pkg.sv
src/bmm_bank_ram.sv
src/bmm_mod_unit.sv
src/banked_memory_mapper_unit.sv
sim/banked_memory_mapper_unit_tb.sv
